>>> rtl/core/tilteq_pkg.sv
// Package of the tilt equalizer biquad cascade.
// Holds the shared constants, register indexes, state and control types.
// No dependencies.
`default_nettype none
package tilteq_pkg;

  localparam int CH_W      = 3;
  localparam int COEF_W    = 32;
  localparam int NUM_COEFS = 8;
  localparam int CFG_IDX_W = 3;
  localparam int DIGIT_W   = 8;
  localparam int ACC_W     = 64;
  localparam int STEP_W    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_B0  = 3'd0,
    REG_LOW_B1  = 3'd1,
    REG_LOW_B2  = 3'd2,
    REG_HIGH_B0 = 3'd3,
    REG_HIGH_B1 = 3'd4,
    REG_HIGH_B2 = 3'd5,
    REG_POLE_A1 = 3'd6,
    REG_POLE_A2 = 3'd7
  } coef_idx_t;

  typedef enum logic [STEP_W-1:0] {
    STEP_LOW_B0  = 4'd0,
    STEP_LOW_B1  = 4'd1,
    STEP_LOW_B2  = 4'd2,
    STEP_LOW_A1  = 4'd3,
    STEP_LOW_A2  = 4'd4,
    STEP_HIGH_B0 = 4'd5,
    STEP_HIGH_B1 = 4'd6,
    STEP_HIGH_B2 = 4'd7,
    STEP_HIGH_A1 = 4'd8,
    STEP_HIGH_A2 = 4'd9
  } step_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_MAC  = 2'd2,
    ST_DONE = 2'd3
  } state_t;

  typedef struct packed {
    logic start;
    logic clear;
  } mac_cmd_t;

endpackage
`default_nettype wire

>>> rtl/core/tilteq_in_if.sv
// Input channel interface of the tilt equalizer: valid, ready and payload.
// Depends on tilteq_pkg.
`default_nettype none
interface tilteq_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                           valid;
  logic                           ready;
  logic [tilteq_pkg::CH_W-1:0]    channel;
  logic signed [SAMPLE_BITS-1:0]  sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink   (input valid, input channel, input sample_in, output ready);
endinterface
`default_nettype wire

>>> rtl/core/tilteq_out_if.sv
// Result channel interface of the tilt equalizer: valid, ready and payload.
// Depends on tilteq_pkg.
`default_nettype none
interface tilteq_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                           valid;
  logic                           ready;
  logic [tilteq_pkg::CH_W-1:0]    out_channel;
  logic signed [SAMPLE_BITS-1:0]  sample_out;

  modport source (output valid, output out_channel, output sample_out, input ready);
  modport sink   (input valid, input out_channel, input sample_out, output ready);
endinterface
`default_nettype wire

>>> rtl/core/tilteq_mac.sv
// Digit-serial multiply-accumulate unit with rounding and saturation.
// Consumes one operand digit per cycle. Depends on tilteq_pkg.
`default_nettype none
module tilteq_mac #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 26
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  tilteq_pkg::mac_cmd_t                 cmd,
  input  wire signed [tilteq_pkg::COEF_W:0]    coef,
  input  wire signed [SAMPLE_BITS-1:0]         operand,
  output logic                                 done,
  output logic signed [SAMPLE_BITS-1:0]        sat
);
  import tilteq_pkg::*;

  localparam int NDIG  = (SAMPLE_BITS + DIGIT_W - 1) / DIGIT_W;
  localparam int OPW   = NDIG * DIGIT_W;
  localparam int K_W   = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int PP_W  = COEF_W + 1 + DIGIT_W + 1;
  localparam logic signed [ACC_W-1:0] SAT_HI =
    ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
  localparam logic [ACC_W-1:0] RND = ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));
  localparam logic [K_W-1:0] K_LAST = K_W'(NDIG - 1);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [K_W-1:0]            k_r, k_nxt;
  logic signed [OPW-1:0]     opnd_r, opnd_nxt;
  logic signed [COEF_W:0]    coef_r, coef_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [DIGIT_W:0]   digit;
  logic signed [PP_W-1:0]    pp;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   rnd;
  logic signed [ACC_W-1:0]   shr;

  assign digit = {(k_r == K_LAST) & opnd_r[DIGIT_W-1], opnd_r[DIGIT_W-1:0]};
  assign pp    = coef_r * digit;
  assign term  = ACC_W'(pp) <<< (32'(k_r) * DIGIT_W);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    k_nxt    = k_r;
    opnd_nxt = opnd_r;
    coef_nxt = coef_r;
    acc_nxt  = acc_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
      opnd_nxt = OPW'(operand);
      coef_nxt = coef;
      if (cmd.clear) begin
        acc_nxt = '0;
      end
    end else if (busy_r) begin
      acc_nxt  = acc_r + term;
      opnd_nxt = opnd_r >>> DIGIT_W;
      k_nxt    = k_r + K_W'(1);
      if (k_r == K_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      k_r    <= k_nxt;
    end
    opnd_r <= opnd_nxt;
    coef_r <= coef_nxt;
    acc_r  <= acc_nxt;
  end

  always_comb begin
    rnd = acc_r + RND;
    shr = rnd >>> COEF_FRAC_BITS;
    if (shr > SAT_HI) begin
      sat = SAT_HI[SAMPLE_BITS-1:0];
    end else if (shr < SAT_LO) begin
      sat = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat = shr[SAMPLE_BITS-1:0];
    end
  end

  assign done = done_r;

endmodule
`default_nettype wire

>>> rtl/core/tilteq_hist.sv
// Per-channel filter history memory with registered read.
// Entries that were never written read as zero. Depends on tilteq_pkg.
`default_nettype none
module tilteq_hist #(
  parameter int MAX_CHANNELS = 8,
  parameter int WORD_W       = 144
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     rd_en,
  input  wire [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] rd_addr,
  output logic [WORD_W-1:0]       rd_data,
  input  wire                     wr_en,
  input  wire [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] wr_addr,
  input  wire [WORD_W-1:0]        wr_data
);
  import tilteq_pkg::*;

  logic [WORD_W-1:0]       mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] valid_r;
  logic [WORD_W-1:0]       rd_word_r;
  logic                    rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_word_r : '0;

endmodule
`default_nettype wire

>>> rtl/core/tilt_eq_biquad_cascade.sv
// Tilt equalizer: low-shelf then high-shelf direct-form-I biquad per channel.
// Each transaction's products are formed one after another by the single shared 8-bit
// digit-serial multiply-accumulate unit. One transaction is processed at a time;
// a channel out of range skips the filter and its sample is returned unchanged.
// Synchronous active-low reset restores coefficient defaults and zero histories.
`default_nettype none
module tilt_eq_biquad_cascade #(
  parameter int MAX_CHANNELS   = 8,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 26
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  tilteq_in_if.sink                             in_bus,
  tilteq_out_if.source                          out_bus,
  input  wire                                   cfg_we,
  input  wire [tilteq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [tilteq_pkg::COEF_W-1:0]          cfg_data
);
  import tilteq_pkg::*;

  localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SB       = SAMPLE_BITS;
  localparam int WORD_W   = 6 * SB;
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1 << COEF_FRAC_BITS);

  logic [COEF_W-1:0] coef_r [NUM_COEFS];

  state_t                 state_r, state_nxt;
  step_t                  step_r, step_nxt, step_next;
  logic [CH_W-1:0]        ch_r;
  logic signed [SB-1:0]   x_r, m_r, y_r;
  logic                   out_valid_r;
  logic [CH_W-1:0]        out_ch_r;
  logic signed [SB-1:0]   out_sample_r;

  logic                   accept, in_range, out_load, last_done;
  mac_cmd_t               mac_cmd;
  logic                   mac_start, mac_clear;
  logic signed [COEF_W:0] mac_coef;
  logic signed [SB-1:0]   mac_opnd;
  logic                   mac_done;
  logic signed [SB-1:0]   mac_sat;
  logic [WORD_W-1:0]      hist_rd, hist_wr;
  logic                   hist_we;
  logic signed [SB-1:0]   h_in1, h_in2, h_mid1, h_mid2, h_out1, h_out2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_r[i] <= '0;
      end
      coef_r[REG_LOW_B0]  <= COEF_ONE;
      coef_r[REG_HIGH_B0] <= COEF_ONE;
    end else if (cfg_we) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  assign accept    = in_bus.valid && in_bus.ready;
  assign in_range  = 32'(in_bus.channel) < MAX_CHANNELS;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_bus.ready);
  assign last_done = (state_r == ST_MAC) && mac_done && (step_r == STEP_HIGH_A2);

  assign {h_out2, h_out1, h_mid2, h_mid1, h_in2, h_in1} = hist_rd;
  assign hist_wr = {h_out1, mac_sat, h_mid1, m_r, h_in1, x_r};
  assign hist_we = last_done;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = in_range ? ST_READ : ST_DONE;
        end
      end
      ST_READ: state_nxt = ST_MAC;
      ST_MAC: begin
        if (last_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_bus.ready = 1'b0;
    mac_start    = 1'b0;
    unique case (state_r)
      ST_IDLE: in_bus.ready = 1'b1;
      ST_READ: mac_start    = 1'b1;
      ST_MAC:  mac_start    = mac_done && (step_r != STEP_HIGH_A2);
      ST_DONE: in_bus.ready = 1'b0;
      default: in_bus.ready = 1'b0;
    endcase
  end

  assign step_next = (state_r == ST_READ) ? STEP_LOW_B0 : step_t'(step_r + 4'd1);
  assign mac_clear = (step_next == STEP_LOW_B0) || (step_next == STEP_HIGH_B0);
  assign mac_cmd   = '{start: mac_start, clear: mac_clear};

  always_comb begin
    mac_coef = '0;
    mac_opnd = '0;
    case (step_next)
      STEP_LOW_B0: begin
        mac_coef = {coef_r[REG_LOW_B0][COEF_W-1], coef_r[REG_LOW_B0]};
        mac_opnd = x_r;
      end
      STEP_LOW_B1: begin
        mac_coef = {coef_r[REG_LOW_B1][COEF_W-1], coef_r[REG_LOW_B1]};
        mac_opnd = h_in1;
      end
      STEP_LOW_B2: begin
        mac_coef = {coef_r[REG_LOW_B2][COEF_W-1], coef_r[REG_LOW_B2]};
        mac_opnd = h_in2;
      end
      STEP_LOW_A1: begin
        mac_coef = -$signed({coef_r[REG_POLE_A1][COEF_W-1], coef_r[REG_POLE_A1]});
        mac_opnd = h_mid1;
      end
      STEP_LOW_A2: begin
        mac_coef = -$signed({coef_r[REG_POLE_A2][COEF_W-1], coef_r[REG_POLE_A2]});
        mac_opnd = h_mid2;
      end
      STEP_HIGH_B0: begin
        mac_coef = {coef_r[REG_HIGH_B0][COEF_W-1], coef_r[REG_HIGH_B0]};
        mac_opnd = mac_sat;
      end
      STEP_HIGH_B1: begin
        mac_coef = {coef_r[REG_HIGH_B1][COEF_W-1], coef_r[REG_HIGH_B1]};
        mac_opnd = h_mid1;
      end
      STEP_HIGH_B2: begin
        mac_coef = {coef_r[REG_HIGH_B2][COEF_W-1], coef_r[REG_HIGH_B2]};
        mac_opnd = h_mid2;
      end
      STEP_HIGH_A1: begin
        mac_coef = -$signed({coef_r[REG_POLE_A1][COEF_W-1], coef_r[REG_POLE_A1]});
        mac_opnd = h_out1;
      end
      STEP_HIGH_A2: begin
        mac_coef = -$signed({coef_r[REG_POLE_A2][COEF_W-1], coef_r[REG_POLE_A2]});
        mac_opnd = h_out2;
      end
      default: begin
        mac_coef = '0;
        mac_opnd = '0;
      end
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (state_r == ST_READ) begin
      step_nxt = STEP_LOW_B0;
    end else if (state_r == ST_MAC && mac_done && step_r != STEP_HIGH_A2) begin
      step_nxt = step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_LOW_B0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      ch_r <= in_bus.channel;
      x_r  <= in_bus.sample_in;
      y_r  <= in_bus.sample_in;
    end
    if (state_r == ST_MAC && mac_done && step_r == STEP_LOW_A2) begin
      m_r <= mac_sat;
    end
    if (last_done) begin
      y_r <= mac_sat;
    end
    if (out_load) begin
      out_ch_r     <= ch_r;
      out_sample_r <= y_r;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.out_channel = out_ch_r;
  assign out_bus.sample_out  = out_sample_r;

  tilteq_mac #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (mac_cmd),
    .coef    (mac_coef),
    .operand (mac_opnd),
    .done    (mac_done),
    .sat     (mac_sat)
  );

  tilteq_hist #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .WORD_W       (WORD_W)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (CH_IDX_W'(in_bus.channel)),
    .rd_data (hist_rd),
    .wr_en   (hist_we),
    .wr_addr (CH_IDX_W'(ch_r)),
    .wr_data (hist_wr)
  );

  a_done_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == ST_MAC)
    else $error("MAC completion outside the MAC state");

  a_hist_last: assert property (@(posedge clk) disable iff (!rst_n)
    hist_we |-> (step_r == STEP_HIGH_A2 && state_r == ST_MAC))
    else $error("History written before the last product");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == ST_IDLE))
    else $error("Result register not loaded on completion");

endmodule
`default_nettype wire

>>> verif/tilteq_checker.sv
// Checker for the tilt equalizer cascade: watches the sample, result and coefficient ports,
// predicts each filtered sample, and compares it with what the block returns.
// Depends on tilteq_pkg, tilteq_in_if and tilteq_out_if.
`default_nettype none
module tilteq_checker (
  input  wire                              clk,
  input  wire                              rst_n,
  tilteq_in_if                             in_mon,
  tilteq_out_if                            out_mon,
  input  wire                              cfg_we,
  input  wire [tilteq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [tilteq_pkg::COEF_W-1:0]     cfg_data,
  output int                               fail_count,
  output int                               pending
);
  import tilteq_pkg::*;

  localparam longint UNITY    = 64'sd1 <<< 26;
  localparam longint HALF_LSB = 64'sd1 <<< 25;
  localparam longint SMP_MAX  = 64'sd8388607;
  localparam longint SMP_MIN  = -64'sd8388608;

  typedef struct {
    logic [CH_W-1:0]    ch;
    logic signed [23:0] smp;
  } filtered_t;

  filtered_t filtered_q[$];
  longint    coefs[NUM_COEFS];
  longint    in_h1[8], in_h2[8], mid_h1[8], mid_h2[8], out_h1[8], out_h2[8];

  function automatic longint shelf_out(longint b0, longint b1, longint b2, longint x,
                                       longint x1, longint x2, longint y1, longint y2);
    longint acc;
    acc = b0 * x + b1 * x1 + b2 * x2 - coefs[REG_POLE_A1] * y1 - coefs[REG_POLE_A2] * y2;
    acc = (acc + HALF_LSB) >>> 26;
    if (acc > SMP_MAX) return SMP_MAX;
    if (acc < SMP_MIN) return SMP_MIN;
    return acc;
  endfunction

  always @(posedge clk) begin
    longint    x, m, y;
    int        c;
    filtered_t got, want;
    if (!rst_n) begin
      foreach (coefs[i]) coefs[i] = 0;
      coefs[REG_LOW_B0] = UNITY;
      coefs[REG_HIGH_B0] = UNITY;
      foreach (in_h1[i]) begin
        in_h1[i] = 0; in_h2[i] = 0; mid_h1[i] = 0; mid_h2[i] = 0; out_h1[i] = 0; out_h2[i] = 0;
      end
      filtered_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) coefs[cfg_index] = longint'($signed(cfg_data));
      if (in_mon.valid && in_mon.ready) begin
        c = int'(in_mon.channel);
        x = longint'(in_mon.sample_in);
        m = shelf_out(coefs[REG_LOW_B0], coefs[REG_LOW_B1], coefs[REG_LOW_B2], x,
                      in_h1[c], in_h2[c], mid_h1[c], mid_h2[c]);
        y = shelf_out(coefs[REG_HIGH_B0], coefs[REG_HIGH_B1], coefs[REG_HIGH_B2], m,
                      mid_h1[c], mid_h2[c], out_h1[c], out_h2[c]);
        in_h2[c] = in_h1[c];   in_h1[c] = x;
        mid_h2[c] = mid_h1[c]; mid_h1[c] = m;
        out_h2[c] = out_h1[c]; out_h1[c] = y;
        want.ch = in_mon.channel;
        want.smp = y[23:0];
        filtered_q.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.ch = out_mon.out_channel;
        got.smp = out_mon.sample_out;
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected transaction ch=%0d sample=%0d", $time, got.ch, got.smp);
          fail_count++;
        end else begin
          want = filtered_q.pop_front();
          if (got.ch !== want.ch) begin
            $display("%0t: channel expected %0d actual %0d", $time, want.ch, got.ch);
            fail_count++;
          end
          if (got.smp !== want.smp) begin
            $display("%0t: sample expected %0d actual %0d", $time, want.smp, got.smp);
            fail_count++;
          end
        end
      end
    end
    pending = filtered_q.size();
  end
endmodule
`default_nettype wire

>>> verif/tb.sv
// Top of the tilt equalizer testbench: clock, reset, coefficient phases and sample stimulus.
// Instantiates the cascade and tilteq_checker; depends on tilteq_pkg and both interfaces.
`default_nettype none
module tb;
  import tilteq_pkg::*;

  localparam int IDLE_LIMIT = 6000;
  localparam int PHASE_ITEMS = 180;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data = '0;
  logic                 no_idle = 1'b0;
  int                   hold_token = 0;
  int                   seen_token = 0;
  int                   stall_left = 0;
  int                   idle_cycles = 0;
  int                   fail_count, pending;
  int                   sent = 0;
  int                   phases = 0;
  logic [31:0]          coef_set[8];

  tilteq_in_if  in_bus();
  tilteq_out_if out_bus();

  tilt_eq_biquad_cascade dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tilteq_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_bus), .out_mon(out_bus),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #2 clk = ~clk;

  initial begin
    in_bus.valid = 1'b0;
    in_bus.channel = '0;
    in_bus.sample_in = '0;
    out_bus.ready = 1'b0;
  end

  always @(posedge clk) begin
    int r;
    if (hold_token != seen_token) begin
      seen_token <= hold_token;
      stall_left <= 400;
      out_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_bus.ready <= 1'b0;
    end else if (no_idle) begin
      out_bus.ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) stall_left <= $urandom_range(20, 90);
      else if (r < 20) stall_left <= $urandom_range(1, 3);
      out_bus.ready <= (r >= 20);
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL tilt_eq_biquad_cascade");
      $finish;
    end
  end

  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [23:0] smp);
    int gap, r;
    r = $urandom_range(0, 99);
    gap = no_idle ? 0 : (r < 60 ? 0 : (r < 95 ? $urandom_range(1, 4) : $urandom_range(20, 80)));
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.channel <= ch;
    in_bus.sample_in <= smp;
    do @(posedge clk); while (!in_bus.ready);
    sent++;
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic load_coefs();
    for (int i = 0; i < NUM_COEFS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= coef_idx_t'(i);
      cfg_data <= coef_set[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    phases++;
  endtask

  function automatic logic [23:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'h7FFFFF;
    if (r == 1) return 24'h800000;
    if (r == 2) return 24'($signed($urandom_range(0, 512)) - 256);
    return 24'($urandom);
  endfunction

  function automatic logic [31:0] near_unity();
    return 32'($signed($urandom_range(0, 32'h0C00_0000)) - 32'sh0600_0000);
  endfunction

  initial begin
    logic [CH_W-1:0] ch;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int c = 0; c < 8; c++) begin
      send_sample(CH_W'(c), 24'h7FFFFF);
      send_sample(CH_W'(c), 24'h800000);
    end
    send_sample(3'd0, 24'h000000);
    send_sample(3'd7, 24'hFFFFFF);
    send_sample(3'd5, 24'h000001);
    send_sample(3'd2, 24'h555555);
    send_sample(3'd2, 24'hAAAAAA);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      case (p)
        0: coef_set = '{32'd73819750, -32'sd114085069, 32'd43620762, 32'd60397978,
                        -32'sd107374182, 32'd48318382, -32'sd120795955, 32'd54358180};
        1: foreach (coef_set[i]) coef_set[i] = 32'h7FFF_FFFF;
        2: foreach (coef_set[i]) coef_set[i] = 32'h8000_0000;
        3: foreach (coef_set[i]) coef_set[i] = $urandom;
        4: foreach (coef_set[i]) coef_set[i] = near_unity();
        default: coef_set = '{32'h0400_0000, 0, 0, 32'h0400_0000, 0, 0, 0, 0};
      endcase
      load_coefs();
      no_idle <= (p == 4);
      if (p == 1) hold_token <= hold_token + 1;
      ch = CH_W'($urandom_range(0, 7));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 3) != 0) ch = CH_W'($urandom_range(0, 7));
        send_sample(ch, pick_sample());
      end
    end

    in_bus.valid <= 1'b0;
    no_idle <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Run covered %0d samples over %0d coefficient sets after reset defaults.",
             sent, phases);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS tilt_eq_biquad_cascade");
    end else begin
      $display("FAIL tilt_eq_biquad_cascade");
    end
    $finish;
  end
endmodule
`default_nettype wire
